// ----- sv/eg2cp_pkg.sv -----
// shared types and constants for the elevation grid to colored points block
`default_nettype none
package eg2cp_pkg;
    localparam logic signed [31:0] FIXED_NODATA = -32'sd9999;
    localparam logic signed [31:0] MIN_RESET = 32'sd999999900;
    localparam logic signed [31:0] MAX_RESET = -32'sd999999900;
    localparam logic [2:0] REG_COLS = 3'd0;
    localparam logic [2:0] REG_ROWS = 3'd1;
    localparam logic [2:0] REG_OX = 3'd2;
    localparam logic [2:0] REG_OY = 3'd3;
    localparam logic [2:0] REG_CELL = 3'd4;
    localparam logic [2:0] REG_NODATA = 3'd5;
    localparam logic [2:0] REG_COLOR = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MULX,
        ST_DIV,
        ST_COLOR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } ctl_t;

    // knot tables in thousandths, five knots per channel, case key {channel, k}
    function automatic logic [9:0] knot(input logic [1:0] ch, input logic [2:0] k);
        logic [9:0] v;
        v = 10'd0;
        case ({ch, k})
            5'b00_000: v = 10'd267;
            5'b00_001: v = 10'd282;
            5'b00_010: v = 10'd127;
            5'b00_011: v = 10'd267;
            5'b00_100: v = 10'd993;
            5'b01_000: v = 10'd4;
            5'b01_001: v = 10'd141;
            5'b01_010: v = 10'd570;
            5'b01_011: v = 10'd678;
            5'b01_100: v = 10'd906;
            5'b10_000: v = 10'd329;
            5'b10_001: v = 10'd435;
            5'b10_010: v = 10'd704;
            5'b10_011: v = 10'd653;
            5'b10_100: v = 10'd569;
            default: v = 10'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- sv/eg2cp_serial_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module eg2cp_serial_div #(
    parameter int NW = 33,
    parameter int QW = 17
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire eg2cp_pkg::ctl_t ctl,
    input  wire logic [NW-1:0] num,
    input  wire logic [NW-1:0] den,
    output logic               done,
    output logic [QW-1:0]      quo
);
    localparam int CW = $clog2(QW + 1);
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg, num_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic [NW:0]   trial;

    // upper numerator bits are known to be below den and preload the remainder
    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        trial = {rem_reg, num_reg[NW-1]} - {1'b0, den};
        if (ctl.start)
        begin
            rem_next = {{QW{1'b0}}, num[NW-1:QW]};
            num_next = {num[QW-1:0], {(NW-QW){1'b0}}};
            quo_next = '0;
            cnt_next = CW'(QW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (!trial[NW])
            begin
                rem_next = trial[NW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[NW-2:0], num_reg[NW-1]};
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign done = !run_reg;
    assign quo = quo_reg;
endmodule
`default_nettype wire

// ----- sv/eg2cp_serial_mul.sv -----
// shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none
module eg2cp_serial_mul #(
    parameter int AW = 27,
    parameter int BW = 17
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire eg2cp_pkg::ctl_t ctl,
    input  wire logic [AW-1:0]   a,
    input  wire logic [BW-1:0]   b,
    output logic                 done,
    output logic [AW+BW-1:0]     prod
);
    localparam int CW = $clog2(BW + 1);
    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    always_comb
    begin
        acc_next = acc_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        if (ctl.start)
        begin
            acc_next = '0;
            b_next = b;
            cnt_next = CW'(BW);
        end
        else if (cnt_reg != '0)
        begin
            acc_next = {acc_reg[AW+BW-2:0], 1'b0}
                + (b_reg[BW-1] ? {{BW{1'b0}}, a} : '0);
            b_next = {b_reg[BW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg <= b_next;
    end

    assign done = (cnt_reg == '0);
    assign prod = acc_reg;
endmodule
`default_nettype wire

// ----- sv/elevation_grid_to_colored_points_core.sv -----
// top level: raster elevation samples to colored points
// One sample is worked on at a time; a new one is accepted only in the idle state.
// A nodata sample goes from the check state straight to the output state. A point
// passes the check state, two runs of the serial multiplier for the column and
// row offsets times the cell size, the serial divider for the color position,
// the color state, which works out and then stores the level of each channel in
// turn, and the output state, which loads the output register; after that the
// block is idle and accepts the next sample. The finished point sits in
// the output register while the next sample is accepted and worked on; only a point
// still waiting there when the next one is finished stalls the block.
`default_nettype none
module elevation_grid_to_colored_points_core #(
    parameter int COLOR_FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic signed [31:0] elevation_centi,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             point_valid,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [15:0]      red_level,
    output logic [15:0]      green_level,
    output logic [15:0]      blue_level,
    output logic [31:0]      point_number,
    output logic signed [31:0] lowest_z,
    output logic signed [31:0] highest_z,
    output logic             grid_done
);
    localparam int F = COLOR_FRAC_BITS;
    localparam int NW = 33 + F;
    localparam int QW = F + 1;
    localparam int MB = 17;
    localparam int PW = 27 + MB;

    logic [15:0] cols_reg, rows_reg;
    logic signed [31:0] ox_reg, oy_reg, nod_reg;
    logic [26:0] cell_reg;
    logic color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 16'd1;
            rows_reg <= 16'd1;
            ox_reg <= '0;
            oy_reg <= '0;
            cell_reg <= 27'd100;
            nod_reg <= eg2cp_pkg::FIXED_NODATA;
            color_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eg2cp_pkg::REG_COLS: cols_reg <= cfg_data[15:0];
                eg2cp_pkg::REG_ROWS: rows_reg <= cfg_data[15:0];
                eg2cp_pkg::REG_OX: ox_reg <= cfg_data;
                eg2cp_pkg::REG_OY: oy_reg <= cfg_data;
                eg2cp_pkg::REG_CELL: cell_reg <= cfg_data[26:0];
                eg2cp_pkg::REG_NODATA: nod_reg <= cfg_data;
                eg2cp_pkg::REG_COLOR: color_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    eg2cp_pkg::state_t state_reg, state_next;
    logic [15:0] col_reg, row_reg;
    logic signed [31:0] min_reg, max_reg;
    logic [31:0] cnt_reg;
    logic signed [31:0] z_reg;
    logic valid_reg, done_reg, pass_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [15:0] xcol_reg;
    logic [16:0] roff_reg;
    logic yneg_reg;
    logic [1:0] ch_reg;
    logic half_reg;
    logic [25:0] w_reg;
    logic [15:0] r_reg, g_reg, b_reg;
    logic [QW-1:0] p_reg;
    logic obusy_reg;

    eg2cp_pkg::ctl_t mul_ctl, div_ctl;
    logic mul_done, div_done;
    logic [16:0] mul_b;
    logic [PW-1:0] prod;
    logic [NW-1:0] div_num, div_den;
    logic [QW-1:0] quo;

    logic is_nod, take, last_col, last_row;
    logic [16:0] row_off;
    logic signed [45:0] ysum;

    // whole-unit value of z equals m, with truncation toward zero
    function automatic logic whole_is(input logic signed [31:0] z,
                                      input logic signed [31:0] m);
        logic signed [39:0] base, lo, hi, zw;
        base = (40'(m) <<< 6) + (40'(m) <<< 5) + (40'(m) <<< 2);
        zw = 40'(z);
        lo = base;
        hi = base;
        if (m > 0)
            hi = base + 40'sd99;
        else if (m < 0)
            lo = base - 40'sd99;
        else
        begin
            lo = -40'sd99;
            hi = 40'sd99;
        end
        return (zw >= lo) && (zw <= hi);
    endfunction

    assign is_nod = whole_is(elevation_centi, nod_reg)
        || whole_is(elevation_centi, eg2cp_pkg::FIXED_NODATA);
    assign take = in_valid && in_ready;
    assign last_col = ({16'd0, col_reg} + 32'd1) >= {16'd0, cols_reg};
    assign last_row = ({16'd0, row_reg} + 32'd1) >= {16'd0, rows_reg};
    assign row_off = (rows_reg >= row_reg) ? {1'b0, rows_reg - row_reg}
                                           : {1'b0, row_reg - rows_reg};
    assign in_ready = (state_reg == eg2cp_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eg2cp_pkg::ST_IDLE: if (take) state_next = eg2cp_pkg::ST_CHECK;
            eg2cp_pkg::ST_CHECK:
                state_next = valid_reg ? eg2cp_pkg::ST_MULX : eg2cp_pkg::ST_OUT;
            eg2cp_pkg::ST_MULX:
                if (mul_done && pass_reg) state_next = eg2cp_pkg::ST_DIV;
            eg2cp_pkg::ST_DIV:
                if (div_done) state_next = eg2cp_pkg::ST_COLOR;
            eg2cp_pkg::ST_COLOR:
                if (ch_reg == 2'd2 && half_reg) state_next = eg2cp_pkg::ST_OUT;
            eg2cp_pkg::ST_OUT: if (!obusy_reg) state_next = eg2cp_pkg::ST_IDLE;
            default: state_next = eg2cp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_ctl = '0;
        div_ctl = '0;
        mul_b = {1'b0, xcol_reg};
        if (state_reg == eg2cp_pkg::ST_CHECK && valid_reg)
            mul_ctl.start = 1'b1;
        if (state_reg == eg2cp_pkg::ST_MULX && mul_done && !pass_reg)
        begin
            mul_ctl.start = 1'b1;
            mul_b = roff_reg;
        end
        if (state_reg == eg2cp_pkg::ST_MULX && mul_done && pass_reg)
            div_ctl.start = 1'b1;
        mul_ctl.busy = !mul_done;
        div_ctl.busy = !div_done;
    end

    assign div_num = {1'(0), 32'(z_reg - min_reg), {F{1'b0}}};
    assign div_den = {{(F+1){1'b0}}, 32'(max_reg - min_reg)};

    eg2cp_serial_mul #(.AW(27), .BW(MB)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctl(mul_ctl), .a(cell_reg), .b(mul_b),
        .done(mul_done), .prod(prod)
    );

    eg2cp_serial_div #(.NW(NW), .QW(QW)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .num(div_num), .den(div_den),
        .done(div_done), .quo(quo)
    );

    // color for the current channel, scaled level then divide by 1000
    localparam logic [QW-1:0] ONE = QW'(1) << F;
    localparam logic [QW-1:0] QTR = QW'(1) << (F - 2);
    localparam logic [26:0] RECIP = 27'd68719477;
    logic [QW-1:0] pc;
    logic [1:0] seg;
    logic [QW+1:0] t;
    logic signed [11:0] c0, c1;
    logic signed [F+14:0] v;
    logic [F+30:0] lvl;
    logic [25:0] w;
    logic [52:0] scaled;
    logic [15:0] lvl16;

    always_comb
    begin
        pc = (max_reg > min_reg) ? p_reg : '0;
        if (pc > ONE) pc = ONE;
        if (pc <= QTR) seg = 2'd0;
        else if (pc <= QW'(2) * QTR) seg = 2'd1;
        else if (pc <= QW'(3) * QTR) seg = 2'd2;
        else seg = 2'd3;
        t = ({2'b0, pc} - {2'b0, QW'(seg) * QTR}) << 2;
        c0 = $signed({2'b0, eg2cp_pkg::knot(ch_reg, {1'b0, seg})});
        c1 = $signed({2'b0, eg2cp_pkg::knot(ch_reg, {1'b0, seg} + 3'd1)});
        v = ((F+15)'(c0) <<< F) + $signed({1'b0, t}) * (F+15)'(c1 - c0);
        if (v < 0) v = '0;
        lvl = (F+31)'(unsigned'(v)) * (F+31)'(65535);
        w = 26'(lvl >> F);
        scaled = 53'(w_reg) * 53'(RECIP);
        lvl16 = 16'(scaled >> 36);
    end

    logic signed [45:0] xsum;
    assign xsum = 46'(ox_reg) + $signed({2'b0, prod});
    assign ysum = yneg_reg ? 46'(oy_reg) - $signed({2'b0, prod})
                           : 46'(oy_reg) + $signed({2'b0, prod});

    function automatic logic signed [31:0] sat(input logic signed [45:0] s);
        if (s > 46'sd2147483647) return 32'sh7fffffff;
        if (s < -46'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eg2cp_pkg::ST_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            min_reg <= eg2cp_pkg::MIN_RESET;
            max_reg <= eg2cp_pkg::MAX_RESET;
            cnt_reg <= '0;
            obusy_reg <= 1'b0;
            pass_reg <= 1'b0;
            ch_reg <= '0;
            half_reg <= 1'b0;
            w_reg <= '0;
            z_reg <= '0;
            valid_reg <= 1'b0;
            done_reg <= 1'b0;
            xcol_reg <= '0;
            roff_reg <= '0;
            yneg_reg <= 1'b0;
            px_reg <= '0;
            py_reg <= '0;
            p_reg <= '0;
            r_reg <= '0;
            g_reg <= '0;
            b_reg <= '0;
            point_valid <= 1'b0;
            point_x <= '0;
            point_y <= '0;
            point_z <= '0;
            red_level <= '0;
            green_level <= '0;
            blue_level <= '0;
            point_number <= '0;
            lowest_z <= '0;
            highest_z <= '0;
            grid_done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready) obusy_reg <= 1'b0;
            if (take)
            begin
                z_reg <= elevation_centi;
                valid_reg <= !is_nod;
                done_reg <= last_col && last_row;
                xcol_reg <= col_reg;
                roff_reg <= row_off;
                yneg_reg <= row_reg > rows_reg;
                pass_reg <= 1'b0;
                ch_reg <= '0;
                half_reg <= 1'b0;
                r_reg <= '0;
                g_reg <= '0;
                b_reg <= '0;
                px_reg <= '0;
                py_reg <= '0;
                if (!is_nod)
                begin
                    if (elevation_centi < min_reg) min_reg <= elevation_centi;
                    if (elevation_centi > max_reg) max_reg <= elevation_centi;
                    cnt_reg <= cnt_reg + 32'd1;
                end
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 16'd1;
                end
                else
                    col_reg <= col_reg + 16'd1;
            end
            if (state_reg == eg2cp_pkg::ST_MULX && mul_done && !pass_reg)
            begin
                pass_reg <= 1'b1;
                px_reg <= sat(xsum);
            end
            if (state_reg == eg2cp_pkg::ST_MULX && mul_done && pass_reg)
                py_reg <= sat(ysum);
            if (state_reg == eg2cp_pkg::ST_DIV && div_done)
                p_reg <= quo;
            if (state_reg == eg2cp_pkg::ST_COLOR)
            begin
                if (!half_reg)
                begin
                    half_reg <= 1'b1;
                    w_reg <= w;
                end
                else
                begin
                    half_reg <= 1'b0;
                    ch_reg <= ch_reg + 2'd1;
                    case (ch_reg)
                        2'd0: r_reg <= color_reg ? lvl16 : '0;
                        2'd1: g_reg <= color_reg ? lvl16 : '0;
                        default: b_reg <= color_reg ? lvl16 : '0;
                    endcase
                end
            end
            if (state_reg == eg2cp_pkg::ST_OUT && !obusy_reg)
            begin
                obusy_reg <= 1'b1;
                point_valid <= valid_reg;
                point_x <= px_reg;
                point_y <= py_reg;
                point_z <= valid_reg ? z_reg : '0;
                red_level <= r_reg;
                green_level <= g_reg;
                blue_level <= b_reg;
                point_number <= cnt_reg;
                lowest_z <= min_reg;
                highest_z <= max_reg;
                grid_done <= done_reg;
            end
        end
    end

    logic unused;
    assign unused = ^{mul_ctl.busy, div_ctl.busy};
    assign out_valid = obusy_reg;
endmodule
`default_nettype wire

// ----- sv/eg2cp_checker.sv -----
// port-level checks for the core, with bind
`default_nettype none
module eg2cp_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic point_valid,
    input wire logic [15:0] red_level,
    input wire logic [31:0] point_number
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("word dropped");
    a_nod: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> red_level == 16'd0) else $error("nodata color");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> $stable(point_number) || !out_valid
        || point_number != 32'd0 || !point_valid) else $error("count");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("one word at a time");
endmodule
bind elevation_grid_to_colored_points_core eg2cp_checker u_chk (.*);
`default_nettype wire
